// ===== rtl/polynomial_bisection_root_macros.svh =====
// Assertion macros for the bisection root finder
`ifndef POLYNOMIAL_BISECTION_ROOT_MACROS_SVH
`define POLYNOMIAL_BISECTION_ROOT_MACROS_SVH
`ifndef ASSERT_OFF
`define PBR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define PBR_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PBR_ASSERT(label, clk, rst, prop)
`define PBR_ASSERT_R(label, clk, prop)
`endif
`endif

// ===== rtl/pbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_pkg
// Types, constants and codes shared by the bisection root finder.
// ----------------------------------------------------------------------------
package pbr_pkg;

  localparam int MAX_STEPS_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS = 7;

  localparam logic [2:0] REG_COEF_4 = 3'd4;
  localparam logic [2:0] REG_TOLERANCE = 3'd5;
  localparam logic [2:0] REG_STEP_LIMIT = 3'd6;

  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NO_BRACKET = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [31:0] interval_start;
    logic signed [31:0] interval_end;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] root_value;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [2:0]         index;
  } cfg_word_t;

  // point selected for evaluation
  typedef enum logic [1:0] {PT_LEFT, PT_RIGHT, PT_MID} point_t;

  typedef struct packed {
    logic   load;      // latch new interval
    logic   eval_go;   // start Horner evaluation
    point_t point;
    logic   save_yl;   // keep value at the left bound
    logic   save_yr;
    logic   bisect;    // replace one bound by the midpoint
  } dp_cmd_t;

  typedef struct packed {
    logic eval_done;
    logic near_zero;
    logic same_sign;   // yl and yr share a sign
    logic limit_hit;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/pbr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_datapath
// Bounds, step counter and a shared multiplier for Horner evaluation.
// ----------------------------------------------------------------------------
`include "polynomial_bisection_root_macros.svh"
module pbr_datapath #(
  parameter int MAX_STEPS = pbr_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = pbr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pbr_pkg::in_word_t          in_word,
  input  logic signed [4:0][31:0]    coef,
  input  logic [30:0]                tolerance,
  input  logic [8:0]                 step_limit,
  input  pbr_pkg::dp_cmd_t           cmd,
  output pbr_pkg::dp_stat_t          stat,
  output logic signed [31:0]         point_value
);

  localparam int CW = $clog2(MAX_STEPS + 1);

  logic signed [31:0] left_bound, right_bound, mid, x;
  logic signed [31:0] yl, yr, horner_acc;
  logic signed [63:0] product;
  logic [2:0]         k;
  logic               busy, mul_phase, eval_done;
  logic [CW-1:0]      step_count, limit;
  logic signed [32:0] sum;
  logic signed [65:0] shifted, added;
  logic signed [31:0] mulq;
  logic [31:0]        absy;

  assign sum = 33'(left_bound) + 33'(right_bound);
  assign mid = sum[32:1];

  always_comb begin
    unique case (cmd.point)
      pbr_pkg::PT_LEFT:  x = left_bound;
      pbr_pkg::PT_RIGHT: x = right_bound;
      default:           x = mid;
    endcase
  end
  assign point_value = x;

  always_comb begin
    logic [8:0] lim9;
    lim9 = (step_limit == 9'd0) ? 9'd1 : step_limit;
    if (32'(lim9) > 32'(MAX_STEPS)) limit = CW'(MAX_STEPS);
    else limit = CW'(lim9);
  end

  assign shifted = (66'(product) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign mulq = pbr_pkg::sat32(shifted);
  assign added = 66'(mulq) + 66'(signed'(coef[k]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      eval_done <= 1'b0;
      step_count <= '0;
      left_bound <= '0;
      right_bound <= '0;
      horner_acc <= '0;
    end else begin
      eval_done <= 1'b0;
      if (cmd.load) begin
        left_bound <= in_word.interval_start;
        right_bound <= in_word.interval_end;
        step_count <= '0;
      end
      if (cmd.eval_go) begin
        busy <= 1'b1;
        mul_phase <= 1'b1;
        horner_acc <= coef[4];
        k <= 3'd3;
      end else if (busy) begin
        if (mul_phase) begin
          product <= horner_acc * x;
          mul_phase <= 1'b0;
        end else begin
          horner_acc <= pbr_pkg::sat32(added);
          mul_phase <= 1'b1;
          if (k == 3'd0) begin
            busy <= 1'b0;
            eval_done <= 1'b1;
          end else begin
            k <= k - 3'd1;
          end
        end
      end
      if (cmd.save_yl) yl <= horner_acc;
      if (cmd.save_yr) yr <= horner_acc;
      if (cmd.bisect) begin
        step_count <= step_count + 1'b1;
        if (horner_acc[31] == yl[31]) left_bound <= mid;
        else right_bound <= mid;
      end
    end
  end

  assign stat.eval_done = eval_done;
  assign absy = horner_acc[31] ? 32'(-33'(horner_acc)) : 32'(horner_acc);
  assign stat.near_zero = absy <= {1'b0, tolerance};
  assign stat.same_sign = yl[31] == yr[31];
  assign stat.limit_hit = (step_count + 1'b1) >= limit;

  `PBR_ASSERT(a_count_bound, clk, rst, cmd.bisect |-> step_count < limit)
  `PBR_ASSERT(a_go_idle, clk, rst, cmd.eval_go |-> !busy)
  `PBR_ASSERT(a_done_pulse, clk, rst, stat.eval_done |=> !stat.eval_done)

endmodule

// ===== rtl/pbr_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbr_control
// Sequencer for bisection rounds and the result register.
// ----------------------------------------------------------------------------
`include "polynomial_bisection_root_macros.svh"
module pbr_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pbr_pkg::out_word_t   out_word,
  output pbr_pkg::dp_cmd_t     cmd,
  input  pbr_pkg::dp_stat_t    stat,
  input  logic signed [31:0]   point_value
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_WAIT, S_DECIDE, S_OUT} state_t;
  state_t state;
  pbr_pkg::point_t point;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.point = point;
    cmd.load = state == S_IDLE && in_valid;
    cmd.eval_go = state == S_EVAL;
    if (state == S_WAIT && stat.eval_done && !stat.near_zero) begin
      cmd.save_yl = point == pbr_pkg::PT_LEFT;
      cmd.save_yr = point == pbr_pkg::PT_RIGHT;
    end
    cmd.bisect = state == S_DECIDE && !stat.same_sign && !stat.limit_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      point <= pbr_pkg::PT_LEFT;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          point <= pbr_pkg::PT_LEFT;
          state <= S_EVAL;
        end
        S_EVAL: state <= S_WAIT;
        S_WAIT: if (stat.eval_done) begin
          if (stat.near_zero) begin
            out_word.root_value <= point_value;
            out_word.status <= pbr_pkg::STATUS_FOUND;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (point == pbr_pkg::PT_MID) begin
            state <= S_DECIDE;
          end else begin
            point <= (point == pbr_pkg::PT_LEFT) ? pbr_pkg::PT_RIGHT : pbr_pkg::PT_MID;
            state <= S_EVAL;
          end
        end
        S_DECIDE: begin
          if (stat.same_sign) begin
            out_word.root_value <= '0;
            out_word.status <= pbr_pkg::STATUS_NO_BRACKET;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (stat.limit_hit) begin
            out_word.root_value <= point_value;
            out_word.status <= pbr_pkg::STATUS_LIMIT;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            point <= pbr_pkg::PT_LEFT;
            state <= S_EVAL;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PBR_ASSERT(a_valid_out, clk, rst, out_valid |-> state == S_OUT)
  `PBR_ASSERT(a_status_code, clk, rst, out_valid |-> out_word.status != 2'd3)
  `PBR_ASSERT(a_done_wait, clk, rst, cmd.bisect |=> state == S_EVAL)

endmodule

// ===== rtl/polynomial_bisection_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_bisection_root
// Bisection root finder for a configured quartic in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage: write coefficients, tolerance and step limit on the cfg channel
// while idle (cfg_ready is always high). Offer an interval word on in_valid;
// it is taken when in_stall is low, which holds only while idle.
// One result word follows on out_valid and holds until out_stall is low.
// Each Horner evaluation has a start step, then a multiply step and an add
// step on the shared multiplier for each coefficient below the top one,
// and a check step. A round evaluates three points (left, right and mid)
// and then makes a decision. A point within tolerance ends the item as
// found. Reset clears the controller, the bounds and the registers to
// their defaults (tolerance 1, limit 64).
// A stalled result blocks the next item until it is taken.
// ----------------------------------------------------------------------------
module polynomial_bisection_root #(
  parameter int MAX_STEPS = pbr_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = pbr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbr_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pbr_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pbr_pkg::cfg_word_t  cfg_word
);

  logic signed [4:0][31:0] coef;
  logic [30:0]             tolerance;
  logic [8:0]              step_limit;
  pbr_pkg::dp_cmd_t        cmd;
  pbr_pkg::dp_stat_t       stat;
  logic signed [31:0]      point_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      tolerance <= 31'd1;
      step_limit <= 9'd64;
    end else if (cfg_valid) begin
      if (cfg_word.index <= pbr_pkg::REG_COEF_4)
        coef[cfg_word.index] <= cfg_word.data;
      else if (cfg_word.index == pbr_pkg::REG_TOLERANCE)
        tolerance <= cfg_word.data[30:0];
      else if (cfg_word.index == pbr_pkg::REG_STEP_LIMIT)
        step_limit <= cfg_word.data[8:0];
    end
  end

  pbr_control u_control (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_word,
    .cmd, .stat, .point_value
  );

  pbr_datapath #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk, .rst, .in_word, .coef, .tolerance, .step_limit, .cmd, .stat, .point_value
  );

endmodule
